@@ hw/rtl/mouse_packet_cursor_tracker_macros.svh @@
// assertion macros shared by the checker
`ifndef MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MPCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpct check failed");

// next-cycle implication, disabled during reset
`define MPCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpct check failed");

`endif

@@ hw/rtl/mpct_pkg.sv @@
`timescale 1ns / 1ps
package mpct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int BYTE_W         = 8;
  localparam int BTN_W          = 3;
  localparam int WHEEL_W        = 4;
  localparam int DELTA_W        = 9;
  localparam int SYNC_BIT       = 3;
  localparam int SIGN_X_BIT     = 4;
  localparam int SIGN_Y_BIT     = 5;
  localparam int OVF_X_BIT      = 6;
  localparam int OVF_Y_BIT      = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y      = 2'd2;

  localparam int MAX_X_RST = 1023;
  localparam int MAX_Y_RST = 767;

  // byte slot in the packet
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  typedef struct packed {
    logic                      valid;
    logic [BTN_W-1:0]          buttons;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [WHEEL_W-1:0]        wheel;
  } pkt_t;

endpackage

@@ hw/rtl/mouse_packet_cursor_tracker.sv @@
`timescale 1ns / 1ps
// channel   dir  beat content (lowest bit first)
// s_axis    in   data_byte[7:0]
// m_axis    out  cursor_x, cursor_y, buttons[2:0], wheel[3:0], zero pad
// cfg       in   cfg_idx_i selects wheel_mode / max_x / max_y, cfg_data_i value
//
// one byte per cycle while m_axis is not stalled: input register, packet assembly + cursor add/clamp, output register
// an accepted beat passes the input register, then the output register, before its result (if any) shows on m_axis
// the cursor add/clamp loop closes combinationally around the position registers
// reset clears byte position, cursor (0,0), wheel_mode 0, max 1023 x 767
// m_axis stall holds the output beat; one more byte waits in the input register
module mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF,
  localparam int FIELD_W   = 2 * COORD_BITS + mpct_pkg::BTN_W + mpct_pkg::WHEEL_W,
  localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [mpct_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mpct_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // byte stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mpct_pkg::BYTE_W-1:0]       s_axis_tdata,  // data_byte
  // cursor reports out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [TDATA_W-1:0]                m_axis_tdata   // cursor_x, cursor_y, buttons, wheel
);

  // configuration registers
  logic                  wheel_mode_q;
  logic [COORD_BITS-1:0] max_x_q, max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q <= 1'b0;
      max_x_q      <= COORD_BITS'(mpct_pkg::MAX_X_RST);
      max_y_q      <= COORD_BITS'(mpct_pkg::MAX_Y_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpct_pkg::REG_WHEEL_MODE: wheel_mode_q <= cfg_data_i[0];
        mpct_pkg::REG_MAX_X:      max_x_q      <= COORD_BITS'(cfg_data_i);
        mpct_pkg::REG_MAX_Y:      max_y_q      <= COORD_BITS'(cfg_data_i);
        default: ; // unknown index ignored
      endcase
    end
  end

  // input register
  logic                          in_valid_q;
  logic [mpct_pkg::BYTE_W-1:0]   in_data_q;
  logic                          advance;
  logic                          step;

  // output register
  logic                          out_valid_q;
  logic [TDATA_W-1:0]            out_data_q;

  // the work stage moves when the output register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
    end
  end

  // packet assembly
  mpct_pkg::pkt_t pkt;

  mpct_packet_asm u_asm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_data_q),
    .wheel_mode_i (wheel_mode_q),
    .pkt_o        (pkt)
  );

  // cursor update
  logic [COORD_BITS-1:0] next_x, next_y;

  mpct_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pkt_i    (pkt),
    .max_x_i  (max_x_q),
    .max_y_i  (max_y_q),
    .next_x_o (next_x),
    .next_y_o (next_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= pkt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pkt.valid) begin
      out_data_q <= TDATA_W'({pkt.wheel, pkt.buttons, next_y, next_x});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ hw/rtl/mpct_packet_asm.sv @@
`timescale 1ns / 1ps
module mpct_packet_asm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [mpct_pkg::BYTE_W-1:0]     byte_i,
  input  logic                            wheel_mode_i,
  output mpct_pkg::pkt_t                  pkt_o
);

  logic [1:0]                      pos_q, pos_d;
  logic [mpct_pkg::BYTE_W-1:0]     store_q [3];
  logic                            sync_drop;
  logic                            last;
  logic [mpct_pkg::BYTE_W-1:0]     flags;
  logic [mpct_pkg::BYTE_W-1:0]     dy_raw;

  always_comb begin
    sync_drop = (pos_q == mpct_pkg::POS_FIRST) && !byte_i[mpct_pkg::SYNC_BIT];
    last      = wheel_mode_i ? (pos_q == mpct_pkg::POS_FOURTH)
                             : (pos_q >= mpct_pkg::POS_THIRD);
    pos_d     = last ? mpct_pkg::POS_FIRST : pos_q + 2'd1;
    flags     = store_q[0];
    // third byte lands in the same beat that may close a short packet
    dy_raw    = (pos_q == mpct_pkg::POS_THIRD) ? byte_i : store_q[2];

    pkt_o.valid   = step_i && !sync_drop && last &&
                    !flags[mpct_pkg::OVF_X_BIT] && !flags[mpct_pkg::OVF_Y_BIT];
    pkt_o.buttons = flags[mpct_pkg::BTN_W-1:0];
    pkt_o.dx      = {flags[mpct_pkg::SIGN_X_BIT], store_q[1]};
    pkt_o.dy      = {flags[mpct_pkg::SIGN_Y_BIT], dy_raw};
    pkt_o.wheel   = (wheel_mode_i && pos_q == mpct_pkg::POS_FOURTH)
                    ? byte_i[mpct_pkg::WHEEL_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= mpct_pkg::POS_FIRST;
    end else if (step_i && !sync_drop) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !sync_drop && pos_q != mpct_pkg::POS_FOURTH) begin
      store_q[pos_q] <= byte_i;
    end
  end

endmodule

@@ hw/rtl/mpct_cursor.sv @@
`timescale 1ns / 1ps
module mpct_cursor #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpct_pkg::pkt_t        pkt_i,
  input  logic [COORD_BITS-1:0] max_x_i,
  input  logic [COORD_BITS-1:0] max_y_i,
  output logic [COORD_BITS-1:0] next_x_o,
  output logic [COORD_BITS-1:0] next_y_o
);

  localparam int SUM_W = COORD_BITS + 2;

  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  function automatic logic [COORD_BITS-1:0] clamp(
    input logic signed [SUM_W-1:0] v,
    input logic [COORD_BITS-1:0]   limit
  );
    logic [COORD_BITS-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (v[SUM_W-2:0] > {1'b0, limit}) begin
      r = limit;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  always_comb begin
    sum_x    = $signed({2'b00, pos_x_q}) + SUM_W'(pkt_i.dx);
    // mouse counts up as positive, screen counts down
    sum_y    = $signed({2'b00, pos_y_q}) - SUM_W'(pkt_i.dy);
    next_x_o = clamp(sum_x, max_x_i);
    next_y_o = clamp(sum_y, max_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (pkt_i.valid) begin
      pos_x_q <= next_x_o;
      pos_y_q <= next_y_o;
    end
  end

endmodule

@@ hw/rtl/mpct_checker.sv @@
`timescale 1ns / 1ps
`include "mouse_packet_cursor_tracker_macros.svh"
module mpct_checker #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF,
  localparam int FIELD_W   = 2 * COORD_BITS + mpct_pkg::BTN_W + mpct_pkg::WHEEL_W,
  localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [TDATA_W-1:0]          m_axis_tdata
);

  // a stalled beat holds
  `MPCT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a fresh report follows a byte taken through the input register and then the output register
  `MPCT_ASSERT_NOW(a_out_latency, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

  // pad bits above the wheel count stay zero
  `MPCT_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[TDATA_W-1:FIELD_W] == '0)

  // with the output drained, the input is always ready
  `MPCT_ASSERT_NOW(a_no_dead_stall, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

endmodule

bind mouse_packet_cursor_tracker mpct_checker #(
  .COORD_BITS (COORD_BITS)
) u_mpct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/mouse_packet_cursor_tracker_tb.sv @@
`timescale 1ns / 1ps
module mouse_packet_cursor_tracker_tb;
  import mpct_pkg::*;

  localparam int COORD_W  = COORD_BITS_DEF;
  // report beat layout, lowest bit first: cursor_x, cursor_y, buttons, wheel, zero pad
  localparam int REPORT_W = ((2 * COORD_W + BTN_W + WHEEL_W + 7) / 8) * 8;
  localparam int Y_LSB    = COORD_W;
  localparam int BTN_LSB  = 2 * COORD_W;
  localparam int WHL_LSB  = BTN_LSB + BTN_W;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int PKT_LEN_PLAIN = 3;
  localparam int PKT_LEN_WHEEL = 4;

  localparam int SETTLE_CYCLES  = 6;    // input reg + pipeline, with margin
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BYTES    = 200;
  localparam int NUM_PHASES     = 10;
  localparam int MAX_PRINTS     = 40;

  typedef enum logic [1:0] {ACT_BYTE, ACT_WRITE, ACT_DRAIN} act_kind_e;

  typedef struct {
    act_kind_e                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    value;     // mouse byte in the low bits for ACT_BYTE
  } stim_act_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [BTN_W-1:0]   btn;
    logic [WHEEL_W-1:0] whl;
  } cursor_rpt_t;

  // ---------------------------------------------------------------------------
  // clock, dut ports
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata  = '0;   // data_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [REPORT_W-1:0]   m_axis_tdata;         // cursor_x, cursor_y, buttons, wheel, pad

  always #6 clk_i = ~clk_i;

  mouse_packet_cursor_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  stim_act_t   pending_q[$];   // bytes, register writes and drain points in order
  cursor_rpt_t report_q[$];    // cursor reports still owed by the dut
  int          err_count      = 0;
  int          byte_total     = 0;
  int          bytes_accepted = 0;
  bit          gen_mode       = 1'b0;   // packet length the generator is building for

  // ---------------------------------------------------------------------------
  // cursor predictor: own copy of mode, limits, packet bytes and position
  // ---------------------------------------------------------------------------
  bit                 mode_q;
  logic [COORD_W-1:0] lim_x, lim_y;
  logic [BYTE_W-1:0]  pkt_bytes [PKT_LEN_PLAIN];
  logic [1:0]         pos_cnt;
  logic [COORD_W-1:0] cur_x, cur_y;

  function automatic logic [COORD_W-1:0] clamp_coord(int v, int lim);
    if (v < 0) return '0;
    if (v > lim) return COORD_W'(lim);
    return COORD_W'(v);
  endfunction

  function automatic void track_byte(logic [BYTE_W-1:0] b);
    int          plen;
    int          at;
    int          dx, dy;
    cursor_rpt_t rpt;
    plen = mode_q ? PKT_LEN_WHEEL : PKT_LEN_PLAIN;
    at   = int'(pos_cnt);
    // lost sync: a leading byte without the always-one bit is dropped
    if (at == int'(POS_FIRST) && !b[SYNC_BIT]) return;
    if (at < int'(POS_FOURTH)) pkt_bytes[at] = b;
    if (at + 1 < plen) begin
      pos_cnt = 2'(at + 1);
      return;
    end
    // packet done, also when a mode change cut it short
    pos_cnt = POS_FIRST;
    if (pkt_bytes[0][OVF_X_BIT] || pkt_bytes[0][OVF_Y_BIT]) return;
    dx = int'(pkt_bytes[1]) - (pkt_bytes[0][SIGN_X_BIT] ? (1 << BYTE_W) : 0);
    dy = int'(pkt_bytes[2]) - (pkt_bytes[0][SIGN_Y_BIT] ? (1 << BYTE_W) : 0);
    // mouse y counts up, screen y counts down
    cur_x   = clamp_coord(int'(cur_x) + dx, int'(lim_x));
    cur_y   = clamp_coord(int'(cur_y) - dy, int'(lim_y));
    rpt.x   = cur_x;
    rpt.y   = cur_y;
    rpt.btn = pkt_bytes[0][BTN_W-1:0];
    rpt.whl = (plen == PKT_LEN_WHEEL && at == int'(POS_FOURTH)) ? b[WHEEL_W-1:0] : '0;
    report_q.push_back(rpt);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [BYTE_W-1:0] v);
    pending_q.push_back('{kind: ACT_BYTE, reg_idx: '0, value: CFG_DATA_W'(v)});
    byte_total++;
  endfunction

  function automatic void push_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    pending_q.push_back('{kind: ACT_WRITE, reg_idx: idx, value: v});
    if (idx == REG_WHEEL_MODE) gen_mode = v[0];
  endfunction

  function automatic void push_drain();
    pending_q.push_back('{kind: ACT_DRAIN, reg_idx: '0, value: '0});
  endfunction

  // packet header with sync bit set, occasional overflow
  function automatic logic [BYTE_W-1:0] rand_head();
    logic [BYTE_W-1:0] v;
    v = BYTE_W'($urandom);
    v[SYNC_BIT] = 1'b1;
    v[OVF_Y_BIT:OVF_X_BIT] = ($urandom_range(0, 11) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    return v;
  endfunction

  // delta mix: full random, the extreme along the drift, or a magnitude along the drift
  function automatic logic [DELTA_W-1:0] pick_delta(bit up);
    int mag;
    case ($urandom_range(0, 3))
      0: return DELTA_W'($urandom);
      1: return up ? 9'h0FF : 9'h100;
      default: begin
        mag = $urandom_range(0, 255);
        return up ? DELTA_W'(mag) : DELTA_W'(-mag);
      end
    endcase
  endfunction

  function automatic void push_packet(bit drift_x, bit drift_y);
    logic [DELTA_W-1:0] dx, dy;
    logic [BYTE_W-1:0]  head;
    dx   = pick_delta(drift_x);
    dy   = pick_delta(drift_y);
    head = rand_head();
    head[SIGN_X_BIT] = dx[DELTA_W-1];
    head[SIGN_Y_BIT] = dy[DELTA_W-1];
    push_byte(head);
    push_byte(dx[BYTE_W-1:0]);
    push_byte(dy[BYTE_W-1:0]);
    if (gen_mode) push_byte(BYTE_W'($urandom));   // wheel byte, upper nibble is junk
  endfunction

  // ---------------------------------------------------------------------------
  // byte driver: bursts with random gaps, waits for quiet before register writes
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;
  int settle_cnt = 0;

  always @(posedge clk_i) begin : byte_driver
    stim_act_t act;
    logic      nxt_valid;
    logic      nxt_we;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_we_i      <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_byte(s_axis_tdata);
        bytes_accepted++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // beat held until taken
      end else begin
        nxt_valid = 1'b0;
        nxt_we    = 1'b0;
        if (pending_q.size() != 0) begin
          act = pending_q[0];
          if (act.kind == ACT_BYTE) begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              nxt_valid = 1'b1;
              s_axis_tdata <= act.value[BYTE_W-1:0];
              void'(pending_q.pop_front());
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                // mostly short bursts, now and then a long unbroken run
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                         : $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
              end
            end
          end else if (report_q.size() != 0) begin
            settle_cnt = 0;
          end else if (settle_cnt < SETTLE_CYCLES) begin
            // a byte that makes no report may still be inside the dut
            settle_cnt++;
          end else begin
            settle_cnt = 0;
            void'(pending_q.pop_front());
            if (act.kind == ACT_WRITE) begin
              nxt_we = 1'b1;
              cfg_idx_i  <= act.reg_idx;
              cfg_data_i <= act.value;
              case (act.reg_idx)
                REG_WHEEL_MODE: mode_q = act.value[0];
                REG_MAX_X:      lim_x  = act.value[COORD_W-1:0];
                REG_MAX_Y:      lim_y  = act.value[COORD_W-1:0];
                default: ;
              endcase
            end
          end
        end
        s_axis_tvalid <= nxt_valid;
        cfg_we_i      <= nxt_we;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // report monitor: stall pattern cycles through four styles
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      if (err_count < MAX_PRINTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin : report_monitor
    cursor_rpt_t rpt;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (m_axis_tvalid && m_axis_tready) begin
        if (report_q.size() == 0) begin
          if (err_count < MAX_PRINTS)
            $display("%0t: unexpected report, expected none actual %h", $time, m_axis_tdata);
          err_count++;
        end else begin
          rpt = report_q.pop_front();
          check_field("cursor_x", rpt.x, m_axis_tdata[Y_LSB-1:0]);
          check_field("cursor_y", rpt.y, m_axis_tdata[BTN_LSB-1:Y_LSB]);
          check_field("buttons", rpt.btn, m_axis_tdata[WHL_LSB-1:BTN_LSB]);
          check_field("wheel", rpt.whl, m_axis_tdata[WHL_LSB+WHEEL_W-1:WHL_LSB]);
        end
      end
      case (rx_cycle[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2'd2: m_axis_tready <= (rx_cycle[2:0] == 3'd0);
        default: m_axis_tready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no beat in either direction and no write for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no progress for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: directed packets, then random phases over several settings
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int                 ph;
    int                 phase_start;
    bit                 md;
    bit                 drift_x, drift_y;
    logic [COORD_W-1:0] mx, my;

    // predictor starts from the reset state
    mode_q  = 1'b0;
    lim_x   = COORD_W'(MAX_X_RST);
    lim_y   = COORD_W'(MAX_Y_RST);
    pos_cnt = POS_FIRST;
    cur_x   = '0;
    cur_y   = '0;

    // out of sync byte, dropped
    push_byte(8'h00);
    // full positive x, then both signs at their most negative (x clamps at 0)
    push_byte(8'h08); push_byte(8'hFF); push_byte(8'h00);
    push_byte(8'h38); push_byte(8'h00); push_byte(8'h00);
    // both overflow bits, all buttons: discarded
    push_byte(8'hCF); push_byte(8'h12); push_byte(8'h34);
    push_drain();
    // write to a missing register, then wheel mode with junk in the upper bits
    push_write(REG_UNUSED, 12'hFFF);
    push_write(REG_WHEEL_MODE, 12'hFFF);
    // wheel -8 and +7
    push_byte(8'h1D); push_byte(8'h01); push_byte(8'hFF); push_byte(8'h08);
    push_byte(8'h2A); push_byte(8'h80); push_byte(8'h7F); push_byte(8'h07);
    // four-byte packet hit by a mode change after its third byte, closed by the next byte with wheel 0
    push_byte(8'h0F); push_byte(8'h10); push_byte(8'h10);
    push_write(REG_WHEEL_MODE, 12'hFFE);
    push_byte(8'h05);
    // limits dropped below the cursor, clamped at the next packet
    push_write(REG_MAX_X, 12'd0);
    push_write(REG_MAX_Y, 12'd0);
    push_byte(8'h08); push_byte(8'h00); push_byte(8'h00);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin md = 1'b1; mx = 12'd4095; my = 12'd4095; end
        1: begin md = 1'b0; mx = 12'd0;    my = 12'd0;    end
        2: begin md = 1'b1; mx = 12'd4095; my = 12'd0;    end
        3: begin md = 1'b0; mx = 12'd1;    my = 12'd4095; end
        4: begin md = 1'b1; mx = COORD_W'(MAX_X_RST); my = COORD_W'(MAX_Y_RST); end
        default: begin
          md = $urandom_range(0, 1);
          mx = COORD_W'($urandom);
          my = COORD_W'($urandom);
        end
      endcase
      push_write(REG_WHEEL_MODE, {11'($urandom), md});
      push_write(REG_MAX_X, mx);
      push_write(REG_MAX_Y, my);
      drift_x     = $urandom_range(0, 1);
      drift_y     = $urandom_range(0, 1);
      phase_start = byte_total;
      while (byte_total - phase_start < PHASE_BYTES) begin
        case ($urandom_range(0, 15))
          0: push_byte(BYTE_W'($urandom));   // line noise
          1: begin
            // packet broken off early
            push_byte(rand_head());
            repeat ($urandom_range(0, 1)) push_byte(BYTE_W'($urandom));
          end
          default: push_packet(drift_x, drift_y);
        endcase
      end
      // leave a packet half built so the next mode write lands mid-packet
      if ($urandom_range(0, 1) == 1) begin
        push_byte(rand_head());
        repeat ($urandom_range(0, 2)) push_byte(BYTE_W'($urandom));
      end
      if ($urandom_range(0, 3) == 0) push_drain();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || bytes_accepted != byte_total) @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
